// File: rtl/mbd_pkg.sv
// Shared constants and types for the 2x2 box mipmap downsampler.
`timescale 1ns / 1ps

package mbd_pkg;

  // Largest source row and the line store that holds half of it.
  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned LineDepth = MaxWidth / 2;
  // Channels that the block can average at most (the payload always carries four).
  localparam int unsigned Channels  = 4;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned SlotW     = $clog2(LineDepth);
  localparam int unsigned WidthW    = 13;
  localparam int unsigned BppW      = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned LaneW     = ChanW + 1;

  localparam logic [WidthW-1:0] MinWidth    = WidthW'(2);
  localparam logic [WidthW-1:0] MaxWidthVal = WidthW'(MaxWidth);
  localparam logic [BppW-1:0]   MaxBpp      = BppW'(NumLanes);
  localparam logic [BppW-1:0]   ChanLimit   = BppW'(Channels);

  localparam logic [WidthW-1:0] ResetWidth = WidthW'(256);
  localparam logic [BppW-1:0]   ResetBpp   = BppW'(4);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEVEL_WIDTH     = 2'd0,
    CFG_BYTES_PER_PIXEL = 2'd1
  } cfg_reg_e;

  // Four 9-bit per-channel pair sums packed together.
  typedef logic [NumLanes-1:0][LaneW-1:0] lanes_t;

endpackage

// File: rtl/mipmap_box_downsample_top.sv
// Top level of the 2x2 box mipmap downsampler with its pair-sum line store.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake               Payload
//  in        to block   in_valid_i / in_stall_o start_of_image_i, chan0_i..chan3_i
//  out       from block out_valid_o/out_stall_i avg0_o..avg3_o, row_end_o
//  cfg       to block   cfg_we_i                cfg_index_i, cfg_wdata_i
//
// One pixel is taken per clock while the input is not stalled. A result passes through
// the synchronous line-store read and then the output register after the odd-row pixel
// that completes its 2x2 block. Reset clears the column counter, row parity and the
// pipeline valids; the line store has no reset and is not cleared. A stall on the
// output holds the output register first and the read stage next; only when both
// are full and stalled does the input stall.

module mipmap_box_downsample_top
  import mbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                start_of_image_i,
  input  logic [ChanW-1:0]    chan0_i,
  input  logic [ChanW-1:0]    chan1_i,
  input  logic [ChanW-1:0]    chan2_i,
  input  logic [ChanW-1:0]    chan3_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ChanW-1:0]    avg0_o,
  output logic [ChanW-1:0]    avg1_o,
  output logic [ChanW-1:0]    avg2_o,
  output logic [ChanW-1:0]    avg3_o,
  output logic                row_end_o
);

  // Configuration registers.
  logic [WidthW-1:0] level_width_q;
  logic [BppW-1:0]   bpp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_width_q <= ResetWidth;
      bpp_q         <= ResetBpp;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LEVEL_WIDTH:     level_width_q <= cfg_wdata_i[WidthW-1:0];
        CFG_BYTES_PER_PIXEL: bpp_q         <= cfg_wdata_i[BppW-1:0];
        default: ;
      endcase
    end
  end

  logic [WidthW-1:0]   eff_width;
  logic [BppW-1:0]     nch;
  logic [NumLanes-1:0] chan_used;

  always_comb begin
    eff_width = level_width_q;
    if (level_width_q < MinWidth) eff_width = MinWidth;
    else if (level_width_q > MaxWidthVal) eff_width = MaxWidthVal;

    nch = bpp_q;
    if (bpp_q == '0) nch = BppW'(1);
    else if (bpp_q > MaxBpp) nch = MaxBpp;
    if (nch > ChanLimit) nch = ChanLimit;

    for (int c = 0; c < NumLanes; c++) begin
      chan_used[c] = (BppW'(c) < nch);
    end
  end

  // Handshake and pipeline valids.
  logic s1_valid_q, out_valid_q;
  logic out_ready, s1_ready, in_fire;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;
  assign in_fire    = in_valid_i && s1_ready;

  // Row scan state.
  logic [ColW-1:0] col_q, col_d;
  logic            odd_row_q, odd_row_d;
  lanes_t          accum_q, accum_d;

  logic [ColW-1:0]  x;
  logic             odd_row;
  lanes_t           pix, pair;
  logic [SlotW-1:0] slot;
  logic             last_col, row_end;
  logic             line_we, line_re;

  always_comb begin
    x       = start_of_image_i ? '0 : col_q;
    odd_row = start_of_image_i ? 1'b0 : odd_row_q;

    pix[0] = chan_used[0] ? {1'b0, chan0_i} : '0;
    pix[1] = chan_used[1] ? {1'b0, chan1_i} : '0;
    pix[2] = chan_used[2] ? {1'b0, chan2_i} : '0;
    pix[3] = chan_used[3] ? {1'b0, chan3_i} : '0;

    for (int c = 0; c < NumLanes; c++) begin
      pair[c] = accum_q[c] + pix[c];
    end
    slot     = x[ColW-1:1];
    last_col = ({1'b0, x} + WidthW'(1)) >= eff_width;
    row_end  = ({1'b0, x} + WidthW'(2)) >= eff_width;

    line_we = in_fire && x[0] && !odd_row;
    line_re = in_fire && x[0] && odd_row;

    col_d     = col_q;
    odd_row_d = odd_row_q;
    accum_d   = accum_q;
    if (in_fire) begin
      if (!x[0]) accum_d = pix;
      else if (start_of_image_i) accum_d = '0;
      if (last_col) begin
        col_d     = '0;
        odd_row_d = !odd_row;
      end else begin
        col_d     = x + ColW'(1);
        odd_row_d = odd_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      odd_row_q <= 1'b0;
      accum_q   <= '0;
    end else begin
      col_q     <= col_d;
      odd_row_q <= odd_row_d;
      accum_q   <= accum_d;
    end
  end

  // Line store of even-row pair sums. A write and the matching odd-row read are
  // always at least one row apart, so no forwarding is needed.
  lanes_t line_mem [LineDepth];
  lanes_t line_rd_q;

  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[slot] <= pair;
    if (line_re) line_rd_q <= line_mem[slot];
  end

  // Read stage: holds the odd-row pair sum while the line store answers.
  lanes_t s1_pair_q;
  logic   s1_row_end_q;
  logic   s1_valid_d;

  assign s1_valid_d = line_re ? 1'b1 : (out_ready ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_re) begin
      s1_pair_q    <= pair;
      s1_row_end_q <= row_end;
    end
  end

  // Output register: sum of four pixels, divided by four.
  logic [NumLanes-1:0][ChanW-1:0] avg_d, avg_q;
  logic                           row_end_q;

  always_comb begin
    for (int c = 0; c < NumLanes; c++) begin
      logic [LaneW:0] quad;
      quad     = {1'b0, line_rd_q[c]} + {1'b0, s1_pair_q[c]};
      avg_d[c] = chan_used[c] ? quad[LaneW:2] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      avg_q     <= avg_d;
      row_end_q <= s1_row_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign avg0_o      = avg_q[0];
  assign avg1_o      = avg_q[1];
  assign avg2_o      = avg_q[2];
  assign avg3_o      = avg_q[3];
  assign row_end_o   = row_end_q;

  // The line store is never written and read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(line_we && line_re))
    else $error("line store written and read in one cycle");

  // A result waiting in the read stage is kept while the output is full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q)
    else $error("read stage lost a pending result");

  // A new output transfer only follows a filled read stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("output valid without a source in the read stage");

  // Only an odd-row pixel in an odd column reads the line store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_re |-> (odd_row_q && !start_of_image_i && col_q[0]))
    else $error("line store read outside an odd row");

endmodule

// File: test/tb.sv
// Self-checking testbench for the 2x2 box mipmap downsampler.
`timescale 1ns / 1ps

module tb;
  import mbd_pkg::*;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PhaseItems   = 125;
  localparam int unsigned NumPhases    = 8;

  typedef struct packed {
    logic [NumLanes-1:0][ChanW-1:0] avg;
    logic                           row_end;
  } avg_pixel_t;

  // Tracks the downsampler state and the half-size pixels still owed by the block.
  class box_avg_scoreboard;
    lanes_t      line_sums [LineDepth];
    lanes_t      even_pixel;
    int unsigned column;
    bit          odd_row;
    int unsigned width_reg;
    int unsigned bpp_reg;
    avg_pixel_t  owed_q [$];
    int unsigned errors;

    function new();
      foreach (line_sums[i]) line_sums[i] = '0;
      even_pixel = '0;
      column     = 0;
      odd_row    = 1'b0;
      width_reg  = ResetWidth;
      bpp_reg    = ResetBpp;
      errors     = 0;
    endfunction

    function void set_config(cfg_reg_e idx, int unsigned value);
      case (idx)
        CFG_LEVEL_WIDTH:     width_reg = value % 8192;
        CFG_BYTES_PER_PIXEL: bpp_reg   = value % 8;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void note_input(logic sof, logic [NumLanes-1:0][ChanW-1:0] chans);
      int unsigned    w;
      int unsigned    nch;
      int unsigned    x;
      int unsigned    slot;
      int             c;
      lanes_t         pix;
      lanes_t         pair;
      lanes_t         above;
      logic [LaneW:0] sum;
      avg_pixel_t     res;
      w = (width_reg < 2) ? 2 : ((width_reg > MaxWidth) ? MaxWidth : width_reg);
      nch = (bpp_reg < 1) ? 1 : ((bpp_reg > NumLanes) ? NumLanes : bpp_reg);
      if (nch > Channels) nch = Channels;
      if (sof) begin
        column     = 0;
        odd_row    = 1'b0;
        even_pixel = '0;
      end
      x = column;
      for (c = 0; c < NumLanes; c++) begin
        pix[c] = (c < nch) ? {1'b0, chans[c]} : '0;
      end
      if (x % 2 == 0) begin
        even_pixel = pix;
      end else begin
        for (c = 0; c < NumLanes; c++) begin
          pair[c] = even_pixel[c] + pix[c];
        end
        slot = (x >> 1) % LineDepth;
        if (!odd_row) begin
          line_sums[slot] = pair;
        end else begin
          above = line_sums[slot];
          for (c = 0; c < NumLanes; c++) begin
            sum = above[c] + pair[c];
            res.avg[c] = (c < nch) ? sum[LaneW:2] : '0;
          end
          res.row_end = (x + 2 >= w);
          owed_q.push_back(res);
        end
      end
      if (x + 1 >= w) begin
        column  = 0;
        odd_row = ~odd_row;
      end else begin
        column = x + 1;
      end
    endfunction

    function void check_result(logic [NumLanes-1:0][ChanW-1:0] avg, logic row_end);
      avg_pixel_t want;
      bit         bad;
      int         c;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: result with nothing owed: avg=%h row_end=%b", $time, avg, row_end);
        end
        return;
      end
      want = owed_q.pop_front();
      bad  = (row_end !== want.row_end);
      for (c = 0; c < NumLanes; c++) begin
        if (avg[c] !== want.avg[c]) bad = 1'b1;
      end
      if (bad) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: mismatch: expected avg3..0=%h row_end=%b, got avg3..0=%h row_end=%b",
                   $time, want.avg, want.row_end, avg, row_end);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                start_of_image_i;
  logic [ChanW-1:0]    chan0_i;
  logic [ChanW-1:0]    chan1_i;
  logic [ChanW-1:0]    chan2_i;
  logic [ChanW-1:0]    chan3_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ChanW-1:0]    avg0_o;
  logic [ChanW-1:0]    avg1_o;
  logic [ChanW-1:0]    avg2_o;
  logic [ChanW-1:0]    avg3_o;
  logic                row_end_o;

  box_avg_scoreboard sb;
  int unsigned       tx_idle_pct;
  int unsigned       rx_stall_pct;
  int unsigned       rx_hold_left;
  int unsigned       quiet_cycles;

  mipmap_box_downsample_top dut (.*);

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watch both channels; every transfer goes through the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_input(start_of_image_i, {chan3_i, chan2_i, chan1_i, chan0_i});
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result({avg3_o, avg2_o, avg1_o, avg0_o}, row_end_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output side: random stalls, or a long hold-off when one is requested.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left != 0) begin
        out_stall_i <= 1'b1;
        rx_hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  function automatic logic [ChanW-1:0] rand_byte();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel(logic sof, logic [NumLanes-1:0][ChanW-1:0] px);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    start_of_image_i <= sof;
    chan0_i          <= px[0];
    chan1_i          <= px[1];
    chan2_i          <= px[2];
    chan3_i          <= px[3];
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops offering pixels and waits until every owed result has been transferred.
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CfgDataW'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(idx, value);
  endtask

  task automatic run_phase(int unsigned width, int unsigned bpp, int unsigned n_items,
                           bit with_pressure);
    int unsigned                    sent;
    int unsigned                    rows;
    int unsigned                    row_len;
    int unsigned                    p;
    int                             c;
    logic [NumLanes-1:0][ChanW-1:0] px;
    settle_idle();
    write_reg(CFG_LEVEL_WIDTH, width);
    write_reg(CFG_BYTES_PER_PIXEL, bpp);
    row_len = (width < 2) ? 2 : ((width > MaxWidth) ? MaxWidth : width);
    sent    = 0;
    while (sent < n_items) begin
      rows = $urandom_range(1, 5);
      for (p = 0; p < rows * row_len && sent < n_items; p++) begin
        for (c = 0; c < NumLanes; c++) px[c] = rand_byte();
        // A stray start mark now and then breaks the level off early.
        send_pixel((p == 0) || ($urandom_range(49) == 0), px);
        sent++;
        if (with_pressure && sent == n_items / 3) rx_hold_left = HoldCycles;
        if (with_pressure && sent == 2 * n_items / 3) settle_idle();
      end
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned width;
    sb               = new();
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_LEVEL_WIDTH;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    start_of_image_i = 1'b0;
    chan0_i          = '0;
    chan1_i          = '0;
    chan2_i          = '0;
    chan3_i          = '0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    rx_hold_left     = 0;
    quiet_cycles     = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Odd width, so the last column of each row is dropped, and an odd last row.
    write_reg(CFG_LEVEL_WIDTH, 3);
    write_reg(CFG_BYTES_PER_PIXEL, 4);
    send_pixel(1'b1, {8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel(1'b0, {8'd3, 8'd128, 8'd1, 8'd254});
    send_pixel(1'b0, {8'd9, 8'd9, 8'd9, 8'd9});
    send_pixel(1'b0, {8'd255, 8'd255, 8'd0, 8'd255});
    send_pixel(1'b0, {8'd2, 8'd127, 8'd0, 8'd255});
    send_pixel(1'b0, {8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel(1'b0, {8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel(1'b0, {8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel(1'b0, {8'd17, 8'd17, 8'd17, 8'd17});

    // Width below the minimum acts as two; two channels leave the upper averages at zero.
    settle_idle();
    write_reg(CFG_LEVEL_WIDTH, 0);
    write_reg(CFG_BYTES_PER_PIXEL, 2);
    send_pixel(1'b1, {8'd255, 8'd255, 8'd1, 8'd0});
    send_pixel(1'b0, {8'd255, 8'd255, 8'd2, 8'd255});
    send_pixel(1'b0, {8'd255, 8'd255, 8'd3, 8'd0});
    send_pixel(1'b0, {8'd255, 8'd255, 8'd255, 8'd254});

    // Shrinking the width mid-row ends that row at the next pixel.
    settle_idle();
    write_reg(CFG_LEVEL_WIDTH, 6);
    write_reg(CFG_BYTES_PER_PIXEL, 3);
    send_pixel(1'b1, {8'd10, 8'd20, 8'd30, 8'd40});
    send_pixel(1'b0, {8'd50, 8'd60, 8'd70, 8'd80});
    send_pixel(1'b0, {8'd255, 8'd0, 8'd255, 8'd0});
    send_pixel(1'b0, {8'd0, 8'd255, 8'd0, 8'd255});
    settle_idle();
    write_reg(CFG_LEVEL_WIDTH, 2);
    send_pixel(1'b0, {8'd77, 8'd77, 8'd77, 8'd77});
    send_pixel(1'b0, {8'd201, 8'd99, 8'd5, 8'd250});
    send_pixel(1'b0, {8'd200, 8'd98, 8'd6, 8'd251});

    // Width above the maximum acts as the maximum, so the row runs on without an end.
    run_phase(8191, 4, PhaseItems, 1'b0);

    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      width = ($urandom_range(5) == 0) ? $urandom_range(0, 3) : $urandom_range(2, 32);
      run_phase(width, $urandom_range(0, 7), PhaseItems, (phase % 4 == 0));
    end

    settle_idle();
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
